### hdl/cst_pkg.sv
// Package: constants, word types and state encoding for the cosine score block.
`timescale 1ns / 1ps
package cst_pkg;
	localparam int TOP_SLOTS   = 16;
	localparam int SLOT_W      = (TOP_SLOTS > 1) ? $clog2(TOP_SLOTS) : 1;
	localparam int SWEEP_W     = $clog2(TOP_SLOTS + 1) + 1;
	localparam int ACC_W       = 55;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [6:0] COUNT_MAX = 7'd127;
	localparam logic [16:0] ONE_Q16  = 17'd65536;

	localparam logic [1:0] KIND_ELEM  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic CFG_QUERY_TERMS  = 1'b0;
	localparam logic CFG_RESULT_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [23:0] doc_weight;
		logic [23:0] query_weight;
		logic [19:0] doc_id;
		logic        doc_last;
		logic [3:0]  rank;
	} cst_in_t;

	typedef struct packed {
		logic [16:0] out_score;
		logic [19:0] out_doc;
		logic        out_valid;
		logic        out_inserted;
	} cst_out_t;

	typedef struct packed {
		logic [16:0] score;
		logic [19:0] doc;
	} cst_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_SQRT, ST_MUL, ST_DCHK, ST_DIV, ST_MUL2, ST_QDIV, ST_SAT,
		ST_SWEEP, ST_READ
	} cst_state_t;
endpackage

### hdl/cst_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/cosine_score_top_n.sv
// Top level: cosine similarity scoring with a rank-ordered top table.
// Element word: accumulated in ST_ACC. Read word: ST_READ registers the slot and strobes done.
// Document end: the score passes the iterative square roots, the two serial dividers (the
// denominator check may skip them) and the table sweep through the RAM.
// Clear word: taken in idle, no done. One word at a time; done is a one-cycle strobe, never stalled.
// Reset clears accumulators, config (query_terms 1, result_count 10) and all slot valid bits.
`timescale 1ns / 1ps
module cosine_score_top_n (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  cst_pkg::cst_in_t item,
	output logic             done,
	output cst_pkg::cst_out_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [6:0]       cfg_data
);
	import cst_pkg::*;

	cst_state_t state_q, state_d;
	logic [6:0]  query_terms_q;
	logic [4:0]  result_count_q;
	cst_in_t     item_q;
	logic [ACC_W-1:0] dot_q, qn_q, dn_q;
	logic [6:0]  matched_q;
	logic [4:0]  cnt_q;
	logic [55:0] qop_q, dop_q;
	logic [29:0] qrem_q, drem_q;
	logic [27:0] qroot_q, droot_q;
	logic [55:0] den_q, r_q;
	logic [16:0] cos_q;
	logic [23:0] num_q;
	logic [7:0]  qrm_q;
	logic [16:0] score_q;
	logic [SWEEP_W-1:0] j_q;
	logic        placed_q;
	cst_entry_t  carry_q;
	logic [TOP_SLOTS-1:0] vld_q;
	logic        vld_s1;
	logic        done_q;
	cst_out_t    result_q;

	logic        accept;
	logic [SWEEP_W-1:0] n_slots;
	logic [6:0]  qdiv;
	logic        ram_we;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr;
	cst_entry_t  ram_wdata, ram_rdata, entry;
	logic        place;
	logic        sweep_last;
	logic [47:0] p_dot, p_qq, p_dd;
	logic [55:0] s_dot, s_qq, s_dd;
	logic [31:0] qtry, dtry;
	logic [29:0] qtrial, dtrial;
	logic [56:0] r2;
	logic [7:0]  qrm2;

	assign accept = start && !busy;
	assign qdiv   = (query_terms_q == 7'd0) ? 7'd1 : query_terms_q;

	always_comb begin
		if (result_count_q == 5'd0) begin
			n_slots = SWEEP_W'(1);
		end else if (32'(result_count_q) > TOP_SLOTS) begin
			n_slots = SWEEP_W'(TOP_SLOTS);
		end else begin
			n_slots = SWEEP_W'(result_count_q);
		end
	end

	// element arithmetic
	assign p_dot = 48'(item_q.doc_weight) * 48'(item_q.query_weight);
	assign p_qq  = 48'(item_q.query_weight) * 48'(item_q.query_weight);
	assign p_dd  = 48'(item_q.doc_weight) * 48'(item_q.doc_weight);
	assign s_dot = {1'b0, dot_q} + {8'd0, p_dot};
	assign s_qq  = {1'b0, qn_q} + {8'd0, p_qq};
	assign s_dd  = {1'b0, dn_q} + {8'd0, p_dd};

	// square root digit step
	assign qtry   = {qrem_q, qop_q[55:54]};
	assign dtry   = {drem_q, dop_q[55:54]};
	assign qtrial = {qroot_q, 2'b01};
	assign dtrial = {droot_q, 2'b01};

	assign r2   = {r_q, 1'b0};
	assign qrm2 = {qrm_q[6:0], num_q[23]};

	// table sweep
	assign entry      = vld_s1 ? ram_rdata : '0;
	assign sweep_last = (j_q == SWEEP_W'(TOP_SLOTS));
	assign place      = (state_q == ST_SWEEP) && (j_q != '0) && !placed_q &&
		(j_q <= n_slots) && (entry.score < score_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.kind == KIND_ELEM) begin
					state_d = ST_ACC;
				end else if (accept && item.kind == KIND_READ) begin
					state_d = ST_READ;
				end
			end
			ST_ACC:   state_d = item_q.doc_last ? ST_SQRT : ST_IDLE;
			ST_SQRT:  state_d = (cnt_q == 5'd27) ? ST_MUL : ST_SQRT;
			ST_MUL:   state_d = ST_DCHK;
			ST_DCHK: begin
				if (den_q == '0) begin
					state_d = ST_SWEEP;
				end else if ({1'b0, dot_q} >= den_q) begin
					state_d = ST_MUL2;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV:   state_d = (cnt_q == 5'd15) ? ST_MUL2 : ST_DIV;
			ST_MUL2:  state_d = ST_QDIV;
			ST_QDIV:  state_d = (cnt_q == 5'd23) ? ST_SAT : ST_QDIV;
			ST_SAT:   state_d = ST_SWEEP;
			ST_SWEEP: state_d = sweep_last ? ST_IDLE : ST_SWEEP;
			ST_READ:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = carry_q;
		ram_raddr = j_q[SLOT_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = SLOT_W'(item.rank);
			end
			ST_SWEEP: begin
				ram_we    = (j_q != '0) && (place || placed_q);
				ram_waddr = SLOT_W'(j_q - SWEEP_W'(1));
				ram_wdata = place ? cst_entry_t'{score: score_q, doc: item_q.doc_id} : carry_q;
			end
			default: begin
			end
		endcase
	end

	cst_ram #(.WIDTH($bits(cst_entry_t)), .DEPTH(TOP_SLOTS)) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			query_terms_q  <= 7'd1;
			result_count_q <= 5'd10;
			dot_q          <= '0;
			qn_q           <= '0;
			dn_q           <= '0;
			matched_q      <= '0;
			vld_q          <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_SWEEP && sweep_last) || (state_q == ST_READ);
			if (cfg_we) begin
				if (cfg_index == CFG_QUERY_TERMS) begin
					query_terms_q <= cfg_data;
				end else begin
					result_count_q <= cfg_data[4:0];
				end
			end
			if (accept && item.kind == KIND_CLEAR) begin
				vld_q <= '0;
			end
			if (state_q == ST_ACC) begin
				dot_q <= (s_dot >= {1'b0, ACC_MAX}) ? ACC_MAX : s_dot[ACC_W-1:0];
				qn_q  <= (s_qq >= {1'b0, ACC_MAX}) ? ACC_MAX : s_qq[ACC_W-1:0];
				dn_q  <= (s_dd >= {1'b0, ACC_MAX}) ? ACC_MAX : s_dd[ACC_W-1:0];
				if (matched_q < COUNT_MAX) begin
					matched_q <= matched_q + 7'd1;
				end
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (state_q == ST_SWEEP && sweep_last) begin
				dot_q     <= '0;
				qn_q      <= '0;
				dn_q      <= '0;
				matched_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= vld_q[ram_raddr];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q <= item;
				end
			end
			ST_ACC: begin
				cnt_q   <= '0;
				qop_q   <= {1'b0, s_qq >= {1'b0, ACC_MAX} ? ACC_MAX : s_qq[ACC_W-1:0]};
				dop_q   <= {1'b0, s_dd >= {1'b0, ACC_MAX} ? ACC_MAX : s_dd[ACC_W-1:0]};
				qrem_q  <= '0;
				drem_q  <= '0;
				qroot_q <= '0;
				droot_q <= '0;
			end
			ST_SQRT: begin
				cnt_q <= cnt_q + 5'd1;
				qop_q <= {qop_q[53:0], 2'b00};
				dop_q <= {dop_q[53:0], 2'b00};
				if (qtry >= {2'b00, qtrial}) begin
					qrem_q  <= 30'(qtry - {2'b00, qtrial});
					qroot_q <= {qroot_q[26:0], 1'b1};
				end else begin
					qrem_q  <= qtry[29:0];
					qroot_q <= {qroot_q[26:0], 1'b0};
				end
				if (dtry >= {2'b00, dtrial}) begin
					drem_q  <= 30'(dtry - {2'b00, dtrial});
					droot_q <= {droot_q[26:0], 1'b1};
				end else begin
					drem_q  <= dtry[29:0];
					droot_q <= {droot_q[26:0], 1'b0};
				end
			end
			ST_MUL: begin
				den_q <= 56'(qroot_q) * 56'(droot_q);
			end
			ST_DCHK: begin
				cnt_q    <= '0;
				r_q      <= {1'b0, dot_q};
				cos_q    <= ONE_Q16;
				score_q  <= '0;
				j_q      <= '0;
				placed_q <= 1'b0;
			end
			ST_DIV: begin
				// cos_q starts at 1.0, so its low 16 bits are zero and shift out cleanly
				cnt_q <= cnt_q + 5'd1;
				if (r2 >= {1'b0, den_q}) begin
					r_q   <= 56'(r2 - {1'b0, den_q});
					cos_q <= {cos_q[15:0], 1'b1};
				end else begin
					r_q   <= r2[55:0];
					cos_q <= {cos_q[15:0], 1'b0};
				end
			end
			ST_MUL2: begin
				num_q <= 24'(cos_q) * 24'(matched_q);
				qrm_q <= '0;
				cnt_q <= '0;
			end
			ST_QDIV: begin
				cnt_q <= cnt_q + 5'd1;
				if (qrm2 >= {1'b0, qdiv}) begin
					qrm_q <= qrm2 - {1'b0, qdiv};
					num_q <= {num_q[22:0], 1'b1};
				end else begin
					qrm_q <= qrm2;
					num_q <= {num_q[22:0], 1'b0};
				end
			end
			ST_SAT: begin
				score_q <= (num_q > 24'(ONE_Q16)) ? ONE_Q16 : num_q[16:0];
			end
			ST_SWEEP: begin
				j_q <= j_q + SWEEP_W'(1);
				if (j_q != '0) begin
					carry_q <= entry;
					if (place) begin
						placed_q <= 1'b1;
					end
				end
				if (sweep_last) begin
					result_q <= cst_out_t'{out_score: score_q, out_doc: item_q.doc_id,
						out_valid: 1'b0, out_inserted: placed_q || place};
				end
			end
			ST_READ: begin
				if ({28'd0, item_q.rank} < 32'(n_slots)) begin
					result_q <= cst_out_t'{out_score: entry.score, out_doc: entry.doc,
						out_valid: (entry.score != '0), out_inserted: 1'b0};
				end else begin
					result_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE) else $error("result strobe outside idle");
	a_we_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_SWEEP) else $error("table write outside sweep");
	a_score_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> result_q.out_score <= ONE_Q16) else $error("score above one");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.out_valid && result_q.out_inserted))
		else $error("valid and inserted both set");
`endif
endmodule
